### rtl/core/frac_n_synth_program_sequencer_defines.svh
// ----------------------------------------------------------------------------
// frac_n_synth_program_sequencer_defines.svh
// Assertion macros for the synthesizer program sequencer.
// ----------------------------------------------------------------------------
`ifndef FRAC_N_SYNTH_PROGRAM_SEQUENCER_DEFINES_SVH
`define FRAC_N_SYNTH_PROGRAM_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/fnsps_pkg.sv
// ----------------------------------------------------------------------------
// fnsps_pkg
// Widths, register addresses, fixed data words and write formatting.
// ----------------------------------------------------------------------------
package fnsps_pkg;

  localparam int FREQ_W   = 31;
  localparam int GAIN_W   = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 24;
  localparam int K_W      = 6;
  localparam int NINT_W   = 7;
  localparam int QUO_W    = 5;    // quotient bits resolved by the divider stages
  localparam int MHZ_W    = 11;   // 1500 fits in 11 bits
  localparam int PROD_W   = FREQ_W + K_W;
  localparam int REF_SHIFT = 5;   // 32 MHz reference
  localparam int VCO_HALF_MHZ = 1500;

  localparam logic [K_W-1:0] K_MAX = 6'd62;

  // synthesizer register addresses
  localparam logic [ADDR_W-1:0] ADDR_REF_DIV = 5'h02;
  localparam logic [ADDR_W-1:0] ADDR_NINT    = 5'h03;
  localparam logic [ADDR_W-1:0] ADDR_NFRAC   = 5'h04;
  localparam logic [ADDR_W-1:0] ADDR_VCO_SPI = 5'h05;
  localparam logic [ADDR_W-1:0] ADDR_DSM     = 5'h06;
  localparam logic [ADDR_W-1:0] ADDR_CP      = 5'h09;

  // VCO subsystem register addresses
  localparam logic [3:0] VCO_SUB_OUT_DIV = 4'h2;
  localparam logic [3:0] VCO_SUB_MODE    = 4'h3;
  localparam logic [3:0] VCO_SUB_GAIN    = 4'h7;

  // VCO subsystem data with the variable field cleared
  localparam logic [8:0] VCO_OUT_DIV_BASE = 9'h0C0;
  localparam logic [8:0] VCO_GAIN_BASE    = 9'h090;
  localparam logic [8:0] VCO_MODE_WORD    = 9'h09F;

  // full register words
  localparam logic [DATA_W-1:0] REF_DIV_WORD = 24'h000001;
  localparam logic [DATA_W-1:0] DSM_WORD     = 24'h000F4A;
  localparam logic [DATA_W-1:0] CP_WORD      = 24'h2DF264;  // offset code 55
  localparam logic [DATA_W-1:0] AUTOCAL_WORD = 24'h000000;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_OUT_DIV = 10'b00_0000_0010,
    ST_GAIN    = 10'b00_0000_0100,
    ST_MODE    = 10'b00_0000_1000,
    ST_REF_DIV = 10'b00_0001_0000,
    ST_DSM     = 10'b00_0010_0000,
    ST_CP      = 10'b00_0100_0000,
    ST_NINT    = 10'b00_1000_0000,
    ST_AUTOCAL = 10'b01_0000_0000,
    ST_NFRAC   = 10'b10_0000_0000
  } seq_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } reg_write_t;

  // divider datapath width: holds 1500 << frac_bits and f << (QUO_W-1)
  function automatic int div_width(int frac_bits);
    int fmax_w;
    fmax_w = frac_bits + MHZ_W;
    return (fmax_w > FREQ_W + QUO_W) ? fmax_w : FREQ_W + QUO_W;
  endfunction

  function automatic logic [DATA_W-1:0] vco_word(logic [3:0] sub, logic [8:0] vdata);
    return {8'h00, vdata, sub, 3'b000};
  endfunction

  function automatic reg_write_t reg_write(seq_state_t st, logic [K_W-1:0] kdiv,
                                           logic [GAIN_W-1:0] gain,
                                           logic [NINT_W-1:0] nint,
                                           logic [DATA_W-1:0] nfrac);
    reg_write_t w;
    w = '0;
    case (st)
      ST_OUT_DIV: begin
        w.addr = ADDR_VCO_SPI;
        w.data = vco_word(VCO_SUB_OUT_DIV, VCO_OUT_DIV_BASE | {3'b000, kdiv});
      end
      ST_GAIN: begin
        w.addr = ADDR_VCO_SPI;
        w.data = vco_word(VCO_SUB_GAIN, VCO_GAIN_BASE | {5'b00000, gain});
      end
      ST_MODE: begin
        w.addr = ADDR_VCO_SPI;
        w.data = vco_word(VCO_SUB_MODE, VCO_MODE_WORD);
      end
      ST_REF_DIV: begin
        w.addr = ADDR_REF_DIV;
        w.data = REF_DIV_WORD;
      end
      ST_DSM: begin
        w.addr = ADDR_DSM;
        w.data = DSM_WORD;
      end
      ST_CP: begin
        w.addr = ADDR_CP;
        w.data = CP_WORD;
      end
      ST_NINT: begin
        w.addr = ADDR_NINT;
        w.data = DATA_W'(nint);
      end
      ST_AUTOCAL: begin
        w.addr = ADDR_VCO_SPI;
        w.data = AUTOCAL_WORD;
      end
      ST_NFRAC: begin
        w.addr = ADDR_NFRAC;
        w.data = nfrac;
        w.last = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/frac_n_synth_program_sequencer.sv
// A request is registered in the front, divider and mul stages, then loaded into the
// sequencer, which offers the first register write. Writes go one per cycle while
// wr_ready is high; the nine-write sequencer paces requests, the stages ahead of it take
// one per cycle unless stalled; up to seven more requests queue in them while writes drain.
// Reset (rst, synchronous, active high) empties all stages and idles the sequencer.
// ----------------------------------------------------------------------------
// frac_n_synth_program_sequencer
// Fractional-N synthesizer programming: frequency request in, register
// writes out.
// ----------------------------------------------------------------------------
module frac_n_synth_program_sequencer #(
  parameter int FREQ_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [fnsps_pkg::FREQ_W-1:0]  freq_q20,
  input  logic [fnsps_pkg::GAIN_W-1:0]  rf_gain,
  // register write channel
  output logic                          wr_valid,
  input  logic                          wr_ready,
  output logic [fnsps_pkg::ADDR_W-1:0]  reg_addr,
  output logic [fnsps_pkg::DATA_W-1:0]  reg_data,
  output logic                          last_write
);
  import fnsps_pkg::*;

  localparam int DW = div_width(FREQ_FRAC_BITS);
  // dividend of k = 2*floor(1500 / f): 1500 MHz in the input's fixed point
  localparam logic [DW-1:0] FMAX = DW'(VCO_HALF_MHZ) << FREQ_FRAC_BITS;

  // Pipeline, one register stage each:
  //   front    clamp f to 1500 MHz, flag f <= fmax/32 (k saturates at 62)
  //   div x5   restoring division, one quotient bit per stage, MSB first
  //   mul      k = 2*quotient or 62, then k * f
  //   seq      Nint / Nfrac slices, nine writes from a one-hot sequencer
  // front, div and mul each hold a valid bit and stall only when full and blocked.

  logic              dv_valid [0:QUO_W];
  logic              dv_ready [0:QUO_W];
  logic [FREQ_W-1:0] dv_f     [0:QUO_W];
  logic [GAIN_W-1:0] dv_gain  [0:QUO_W];
  logic              dv_big   [0:QUO_W];
  logic [DW-1:0]     dv_rem   [0:QUO_W];
  logic [QUO_W-1:0]  dv_quo   [0:QUO_W];

  logic              mul_valid;
  logic              mul_ready;
  logic [K_W-1:0]    mul_k;
  logic [GAIN_W-1:0] mul_gain;
  logic [PROD_W-1:0] mul_prod;

  fnsps_front #(
    .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .feed_valid  (req_valid),
    .feed_ready  (req_ready),
    .freq_q20    (freq_q20),
    .rf_gain     (rf_gain),
    .stage_valid (dv_valid[0]),
    .stage_ready (dv_ready[0]),
    .stage_f     (dv_f[0]),
    .stage_gain  (dv_gain[0]),
    .stage_big   (dv_big[0])
  );

  // division starts from the constant dividend and an empty quotient
  assign dv_rem[0] = FMAX;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    fnsps_div_step #(
      .FREQ_FRAC_BITS(FREQ_FRAC_BITS),
      .QBIT          (QUO_W - 1 - i)
    ) u_step (
      .clk         (clk),
      .rst         (rst),
      .feed_valid  (dv_valid[i]),
      .feed_ready  (dv_ready[i]),
      .f           (dv_f[i]),
      .gain        (dv_gain[i]),
      .big         (dv_big[i]),
      .rem         (dv_rem[i]),
      .quo         (dv_quo[i]),
      .stage_valid (dv_valid[i+1]),
      .stage_ready (dv_ready[i+1]),
      .stage_f     (dv_f[i+1]),
      .stage_gain  (dv_gain[i+1]),
      .stage_big   (dv_big[i+1]),
      .stage_rem   (dv_rem[i+1]),
      .stage_quo   (dv_quo[i+1])
    );
  end

  // the remainder after the last stage is not needed further on
  fnsps_mul u_mul (
    .clk         (clk),
    .rst         (rst),
    .feed_valid  (dv_valid[QUO_W]),
    .feed_ready  (dv_ready[QUO_W]),
    .f           (dv_f[QUO_W]),
    .gain        (dv_gain[QUO_W]),
    .big         (dv_big[QUO_W]),
    .quo         (dv_quo[QUO_W]),
    .stage_valid (mul_valid),
    .stage_ready (mul_ready),
    .stage_k     (mul_k),
    .stage_gain  (mul_gain),
    .stage_prod  (mul_prod)
  );

  // takes a request when idle, or the next one in the same cycle as the last write's transfer
  fnsps_seq #(
    .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (mul_valid),
    .feed_ready (mul_ready),
    .kdiv       (mul_k),
    .gain       (mul_gain),
    .prod       (mul_prod),
    .wr_valid   (wr_valid),
    .wr_ready   (wr_ready),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last_write (last_write)
  );

endmodule

### rtl/core/fnsps_front.sv
// ----------------------------------------------------------------------------
// fnsps_front
// Input stage: clamps the frequency and flags requests that take k = 62.
// ----------------------------------------------------------------------------
module fnsps_front #(
  parameter int FREQ_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          feed_valid,
  output logic                          feed_ready,
  input  logic [fnsps_pkg::FREQ_W-1:0]  freq_q20,
  input  logic [fnsps_pkg::GAIN_W-1:0]  rf_gain,
  output logic                          stage_valid,
  input  logic                          stage_ready,
  output logic [fnsps_pkg::FREQ_W-1:0]  stage_f,
  output logic [fnsps_pkg::GAIN_W-1:0]  stage_gain,
  output logic                          stage_big
);
  import fnsps_pkg::*;

  localparam int DW = div_width(FREQ_FRAC_BITS);
  localparam logic [DW-1:0] FMAX = DW'(VCO_HALF_MHZ) << FREQ_FRAC_BITS;

  logic [DW-1:0]     f_ext;
  logic [FREQ_W-1:0] f_clamp;
  logic              big;

  assign f_ext   = DW'(freq_q20);
  assign f_clamp = (f_ext > FMAX) ? FREQ_W'(FMAX) : freq_q20;
  // fmax/f >= 32 (zero included): divider saturates at 62
  assign big     = f_ext <= (FMAX >> QUO_W);

  assign feed_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (feed_ready) begin
      stage_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      stage_f    <= f_clamp;
      stage_gain <= rf_gain;
      stage_big  <= big;
    end
  end

endmodule

### rtl/core/fnsps_div_step.sv
// ----------------------------------------------------------------------------
// fnsps_div_step
// One restoring-division stage: resolves quotient bit QBIT of fmax / f.
// ----------------------------------------------------------------------------
module fnsps_div_step #(
  parameter int FREQ_FRAC_BITS = 20,
  parameter int QBIT           = 4
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        feed_valid,
  output logic                                        feed_ready,
  input  logic [fnsps_pkg::FREQ_W-1:0]                f,
  input  logic [fnsps_pkg::GAIN_W-1:0]                gain,
  input  logic                                        big,
  input  logic [fnsps_pkg::div_width(FREQ_FRAC_BITS)-1:0] rem,
  input  logic [fnsps_pkg::QUO_W-1:0]                 quo,
  output logic                                        stage_valid,
  input  logic                                        stage_ready,
  output logic [fnsps_pkg::FREQ_W-1:0]                stage_f,
  output logic [fnsps_pkg::GAIN_W-1:0]                stage_gain,
  output logic                                        stage_big,
  output logic [fnsps_pkg::div_width(FREQ_FRAC_BITS)-1:0] stage_rem,
  output logic [fnsps_pkg::QUO_W-1:0]                 stage_quo
);
  import fnsps_pkg::*;

  localparam int DW = div_width(FREQ_FRAC_BITS);

  logic [DW-1:0]    sub;
  logic             ge;
  logic [DW-1:0]    rem_next;
  logic [QUO_W-1:0] quo_next;

  assign sub      = DW'(f) << QBIT;
  assign ge       = rem >= sub;
  assign rem_next = ge ? (rem - sub) : rem;
  assign quo_next = quo | (QUO_W'(ge) << QBIT);

  assign feed_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (feed_ready) begin
      stage_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      stage_f    <= f;
      stage_gain <= gain;
      stage_big  <= big;
      stage_rem  <= rem_next;
      stage_quo  <= quo_next;
    end
  end

endmodule

### rtl/core/fnsps_mul.sv
// ----------------------------------------------------------------------------
// fnsps_mul
// Picks the output divider k and forms k * f.
// ----------------------------------------------------------------------------
module fnsps_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          feed_valid,
  output logic                          feed_ready,
  input  logic [fnsps_pkg::FREQ_W-1:0]  f,
  input  logic [fnsps_pkg::GAIN_W-1:0]  gain,
  input  logic                          big,
  input  logic [fnsps_pkg::QUO_W-1:0]   quo,
  output logic                          stage_valid,
  input  logic                          stage_ready,
  output logic [fnsps_pkg::K_W-1:0]     stage_k,
  output logic [fnsps_pkg::GAIN_W-1:0]  stage_gain,
  output logic [fnsps_pkg::PROD_W-1:0]  stage_prod
);
  import fnsps_pkg::*;

  logic [K_W-1:0] kdiv;

  // quotient 31 already gives 62, so only the saturated case needs the clamp
  assign kdiv = big ? K_MAX : {quo, 1'b0};

  assign feed_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (feed_ready) begin
      stage_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      stage_k    <= kdiv;
      stage_gain <= gain;
      stage_prod <= PROD_W'(kdiv) * PROD_W'(f);
    end
  end

endmodule

### rtl/core/fnsps_seq.sv
// ----------------------------------------------------------------------------
// fnsps_seq
// Splits k*f into Nint / Nfrac and plays out the nine register writes.
// ----------------------------------------------------------------------------
`include "frac_n_synth_program_sequencer_defines.svh"

module fnsps_seq #(
  parameter int FREQ_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          feed_valid,
  output logic                          feed_ready,
  input  logic [fnsps_pkg::K_W-1:0]     kdiv,
  input  logic [fnsps_pkg::GAIN_W-1:0]  gain,
  input  logic [fnsps_pkg::PROD_W-1:0]  prod,
  output logic                          wr_valid,
  input  logic                          wr_ready,
  output logic [fnsps_pkg::ADDR_W-1:0]  reg_addr,
  output logic [fnsps_pkg::DATA_W-1:0]  reg_data,
  output logic                          last_write
);
  import fnsps_pkg::*;

  localparam int SH = REF_SHIFT + FREQ_FRAC_BITS;

  seq_state_t          state;
  seq_state_t          state_next;
  logic [K_W-1:0]      held_out_div;
  logic [GAIN_W-1:0]   held_gain;
  logic [NINT_W-1:0]   held_int_div;
  logic [DATA_W-1:0]   held_frac_div;

  logic [SH+DATA_W-1:0] frac_ext;
  logic [NINT_W-1:0]    nint;
  logic [DATA_W-1:0]    nfrac;
  reg_write_t           wr;
  logic                 finish;

  // floor(2^24 * frac(prod / 2^SH)) is the top 24 bits of {frac, 24'b0}
  assign frac_ext = {prod[SH-1:0], {DATA_W{1'b0}}};
  assign nfrac    = frac_ext[SH+DATA_W-1:SH];
  assign nint     = prod[SH+NINT_W-1:SH];

  assign wr_valid   = (state != ST_IDLE);
  assign finish     = (state == ST_NFRAC) && wr_ready;
  assign feed_ready = (state == ST_IDLE) || finish;

  assign wr         = reg_write(state, held_out_div, held_gain, held_int_div, held_frac_div);
  assign reg_addr   = wr.addr;
  assign reg_data   = wr.data;
  assign last_write = wr.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (feed_valid) state_next = ST_OUT_DIV;
      ST_OUT_DIV: if (wr_ready) state_next = ST_GAIN;
      ST_GAIN:    if (wr_ready) state_next = ST_MODE;
      ST_MODE:    if (wr_ready) state_next = ST_REF_DIV;
      ST_REF_DIV: if (wr_ready) state_next = ST_DSM;
      ST_DSM:     if (wr_ready) state_next = ST_CP;
      ST_CP:      if (wr_ready) state_next = ST_NINT;
      ST_NINT:    if (wr_ready) state_next = ST_AUTOCAL;
      ST_AUTOCAL: if (wr_ready) state_next = ST_NFRAC;
      ST_NFRAC:   if (wr_ready) state_next = feed_valid ? ST_OUT_DIV : ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      held_out_div  <= kdiv;
      held_gain     <= gain;
      held_int_div  <= nint;
      held_frac_div <= nfrac;
    end
  end

  `FNS_ASSERT_NEXT(a_load_starts, clk, rst, feed_valid && feed_ready, state == ST_OUT_DIV, "load did not start a sequence")
  `FNS_ASSERT_NEXT(a_mid_write_holds, clk, rst, wr_valid && wr_ready && !last_write, wr_valid, "sequence dropped before last write")
  `FNS_ASSERT_IMPL(a_k_even, clk, rst, wr_valid, held_out_div[0] == 1'b0 && held_out_div != '0 && held_out_div <= K_MAX, "output divider out of range")
  `FNS_ASSERT_IMPL(a_load_on_last, clk, rst, wr_valid && feed_ready, last_write && wr_ready, "reload while writes pending")

endmodule

### bench/frac_n_synth_program_sequencer_tb.sv
// ----------------------------------------------------------------------------
// frac_n_synth_program_sequencer_tb
// Sends frequency/gain requests, predicts the nine register writes of each
// from its own divider arithmetic, and checks every write field by field.
// ----------------------------------------------------------------------------
module frac_n_synth_program_sequencer_tb;

  localparam int FRAC_BITS = 20;
  // highest usable output frequency, 1500 MHz in request format
  localparam longint unsigned TOP_FREQ = 64'd1500 << FRAC_BITS;
  // 32 MHz reference: divide by 2^5 on top of the fraction bits
  localparam int N_SHIFT = 5 + FRAC_BITS;
  localparam longint unsigned OUT_DIV_CAP = 64'd62;
  localparam logic [6:0] CP_OFFSET = 7'd55;
  localparam int CLK_HALF = 6;

  typedef struct {
    logic [fnsps_pkg::ADDR_W-1:0] addr;
    logic [fnsps_pkg::DATA_W-1:0] data;
    logic                         last;
  } synth_write_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  logic [fnsps_pkg::FREQ_W-1:0]  freq_q20 = '0;
  logic [fnsps_pkg::GAIN_W-1:0]  rf_gain = '0;
  logic                          wr_valid;
  logic                          wr_ready = 1'b0;
  logic [fnsps_pkg::ADDR_W-1:0]  reg_addr;
  logic [fnsps_pkg::DATA_W-1:0]  reg_data;
  logic                          last_write;

  // register writes predicted for accepted requests, oldest first
  synth_write_t pending_writes[$];
  int mismatches = 0;
  // chance in percent that a side idles in a given cycle
  int idle_pct = 10;
  // write-side hold-off request, picked up by the write monitor
  int hold_request = 0;
  int hold_left = 0;

  frac_n_synth_program_sequencer #(
    .FREQ_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .freq_q20  (freq_q20),
    .rf_gain   (rf_gain),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .reg_addr  (reg_addr),
    .reg_data  (reg_data),
    .last_write(last_write)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(2 * CLK_HALF * 400000);
    $display("frac_n_synth_program_sequencer_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // overwrite bits hi..lo of word with the low bits of val
  function automatic logic [23:0] place_field(logic [23:0] word, logic [23:0] val,
                                              int hi, int lo);
    logic [23:0] mask;
    mask = ((24'h1 << (hi - lo + 1)) - 24'h1) << lo;
    return (word & ~mask) | ((val << lo) & mask);
  endfunction

  // VCO subsystem word carried in the PLL's VCO SPI register
  function automatic logic [23:0] vco_spi_word(logic [3:0] sub, logic [23:0] vdata);
    return place_field(place_field(24'h0, vdata, 15, 7), {20'h0, sub}, 6, 3);
  endfunction

  function automatic void queue_write(logic [4:0] addr, logic [23:0] data, logic last);
    synth_write_t w;
    w.addr = addr;
    w.data = data;
    w.last = last;
    pending_writes.push_back(w);
  endfunction

  // Divider plan for one request, then the nine writes in program order.
  function automatic void predict_program(logic [30:0] freq, logic [3:0] gain);
    longint unsigned f, k, prod, rem;
    logic [6:0]  nint;
    logic [23:0] nfrac;
    logic [23:0] w;
    f = freq;
    if (f > TOP_FREQ) f = TOP_FREQ;          // clamp to 1500 MHz, k = 2
    if (f == 0) k = OUT_DIV_CAP;             // zero acts as lowest frequency
    else begin
      k = 2 * (TOP_FREQ / f);
      if (k > OUT_DIV_CAP) k = OUT_DIV_CAP;
    end
    prod  = k * f;
    nint  = 7'(prod >> N_SHIFT);
    rem   = prod & ((64'd1 << N_SHIFT) - 64'd1);
    nfrac = 24'((rem << 24) >> N_SHIFT);

    w = place_field(24'h0C1, 24'(k[5:0]), 5, 0);
    queue_write(fnsps_pkg::ADDR_VCO_SPI, vco_spi_word(fnsps_pkg::VCO_SUB_OUT_DIV, w), 1'b0);

    w = place_field(24'h0E1, {20'h0, gain}, 3, 0);
    w = place_field(w, 24'h1, 4, 4);
    w = place_field(w, 24'h4, 8, 5);
    queue_write(fnsps_pkg::ADDR_VCO_SPI, vco_spi_word(fnsps_pkg::VCO_SUB_GAIN, w), 1'b0);

    w = place_field(24'h092, 24'h3, 1, 0);
    w = place_field(w, 24'h3, 3, 2);
    queue_write(fnsps_pkg::ADDR_VCO_SPI, vco_spi_word(fnsps_pkg::VCO_SUB_MODE, w), 1'b0);

    queue_write(fnsps_pkg::ADDR_REF_DIV, place_field(24'h000001, 24'h1, 13, 0), 1'b0);

    w = place_field(24'h200B4A, 24'h7, 10, 8);
    w = place_field(w, 24'h0, 21, 21);
    queue_write(fnsps_pkg::ADDR_DSM, w, 1'b0);

    w = place_field(24'h403264, {17'h0, CP_OFFSET}, 20, 14);
    w = place_field(w, 24'h1, 22, 21);
    queue_write(fnsps_pkg::ADDR_CP, w, 1'b0);

    queue_write(fnsps_pkg::ADDR_NINT, place_field(24'h000019, {17'h0, nint}, 18, 0), 1'b0);
    queue_write(fnsps_pkg::ADDR_VCO_SPI, 24'h0, 1'b0);   // autocal retrigger
    queue_write(fnsps_pkg::ADDR_NFRAC, nfrac, 1'b1);
  endfunction

  // One request transfer. Entered and left on a rising edge; valid is only
  // lowered when a gap is taken, so back-to-back transfers keep it high.
  task automatic send_request(input logic [30:0] freq, input logic [3:0] gain);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    req_valid <= 1'b1;
    freq_q20  <= freq;
    rf_gain   <= gain;
    do @(posedge clk); while (req_ready !== 1'b1);
    predict_program(freq, gain);
  endtask

  // Mixed frequency picker: mostly the band where k changes, plus divider
  // boundaries, a log spread, the clamped region and tiny values.
  function automatic logic [30:0] pick_frequency();
    int unsigned sel, n, mask;
    longint unsigned f;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      f = $urandom_range(32'(TOP_FREQ / 31) - 1000, 32'(TOP_FREQ));
    end else if (sel < 65) begin
      n = $urandom_range(1, 31);
      f = TOP_FREQ / n + $urandom_range(0, 4) - 2;
    end else if (sel < 80) begin
      mask = (32'h1 << $urandom_range(1, 31)) - 1;
      f = $urandom & mask;
    end else if (sel < 92) begin
      f = $urandom_range(32'(TOP_FREQ), 32'h7FFF_FFFF);
    end else begin
      f = $urandom_range(0, 1000);
    end
    return 31'(f);
  endfunction

  // Write monitor: compares each write transfer with the oldest prediction
  // and drives wr_ready, honoring a requested hold-off.
  always @(posedge clk) begin : write_monitor
    synth_write_t exp_w;
    if (!rst && wr_valid && wr_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write addr=%02h data=%06h last=%0b",
                                  reg_addr, reg_data, last_write));
      end else begin
        exp_w = pending_writes.pop_front();
        if (reg_addr !== exp_w.addr)
          report_mismatch($sformatf("reg_addr %02h, want %02h", reg_addr, exp_w.addr));
        if (reg_data !== exp_w.data)
          report_mismatch($sformatf("reg_data %06h, want %06h (addr %02h)",
                                    reg_data, exp_w.data, exp_w.addr));
        if (last_write !== exp_w.last)
          report_mismatch($sformatf("last_write %0b, want %0b", last_write, exp_w.last));
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      wr_ready <= 1'b0;
    end else begin
      wr_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Clamp, zero, and the frequencies where k steps; gain at both ends.
  task automatic test_frequency_extremes();
    send_request(31'd0, 4'h0);
    send_request(31'd1, 4'hF);
    send_request(31'(TOP_FREQ / 31), 4'h0);        // last value giving k = 62
    send_request(31'(TOP_FREQ / 31 + 1), 4'hF);    // first value giving k = 60
    send_request(31'(TOP_FREQ / 2), 4'h0);         // k = 4
    send_request(31'(TOP_FREQ / 2 + 1), 4'hF);     // k = 2
    send_request(31'(TOP_FREQ - 1), 4'h0);
    send_request(31'(TOP_FREQ), 4'hF);
    send_request(31'(TOP_FREQ + 1), 4'h0);         // clamped
    send_request(31'h7FFF_FFFF, 4'hF);             // all bits set, clamped
    send_request(31'(64'd100 << FRAC_BITS), 4'h0); // k = 30
  endtask

  task automatic test_gain_codes();
    for (int g = 1; g < 15; g++) send_request(pick_frequency(), 4'(g));
  endtask

  // Random requests; the middle stretch runs with no idling on either side.
  task automatic test_random_requests();
    for (int i = 0; i < 450; i++) begin
      idle_pct = (i >= 150 && i < 260) ? 0 : 10;
      send_request(pick_frequency(), 4'($urandom));
    end
    idle_pct = 10;
  endtask

  // Write side holds off for a long stretch while requests keep coming, so
  // the request stages fill and req_ready must drop.
  task automatic test_write_backpressure();
    idle_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 24; i++) send_request(pick_frequency(), 4'($urandom));
    idle_pct = 10;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_frequency_extremes();
    test_gain_codes();
    test_random_requests();
    test_write_backpressure();

    req_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    // let any stray write surface
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("frac_n_synth_program_sequencer_tb: PASS");
    end else begin
      $display("frac_n_synth_program_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
